### hw/rtl/ewpw_pkg.sv
// shared types, codes and defaults of the echo width presence window
`timescale 1ns / 1ps
`default_nettype none
package ewpw_pkg;

  localparam int unsigned WindowDef    = 10;
  localparam int unsigned TickShiftDef = 4;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned StampW  = 32;
  localparam int unsigned UsW     = 16;
  localparam int unsigned HitCntW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OutW    = 24;
  localparam int unsigned CntMaxW = 6;

  localparam logic [UsW-1:0]     BadEchoUs   = UsW'(10000);
  localparam logic [UsW-1:0]     MinUsRst    = UsW'(50);
  localparam logic [UsW-1:0]     MaxUsRst    = UsW'(800);
  localparam logic [HitCntW-1:0] MinHitsRst  = HitCntW'(3);
  localparam logic [HitCntW-1:0] HitCntSat   = HitCntW'(15);

  typedef enum logic [1:0] {
    FuncTick = 2'd0,
    FuncRise = 2'd1,
    FuncFall = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinUs   = 2'd0,
    CfgMaxUs   = 2'd1,
    CfgMinHits = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic           vld;
    logic [UsW-1:0] width;
  } ewpw_meas_t;

endpackage
`default_nettype wire

### hw/rtl/echo_width_presence_window_unit.sv
// top level: echo width measurement with sliding hit window vote
//
//  channel   dir   handshake                tdata / data                     tuser
//  s_axis    in    s_axis_tvalid/tready     timer_value                      func
//  m_axis    out   m_axis_tvalid/tready     echo_us, hit, hit_count, stop    -
//  cfg       in    cfg_valid_i/cfg_ready_o  cfg_addr_i, cfg_wdata_i          -
//
// one word per cycle while the output is not stalled; a falling edge word gives its result
// through the measure stage and the output register, ticks and rising edges give none
// the measure stage and the output register each hold one word, so input is
// taken while a result waits unless both are full
// the hit window is a shift chain of WINDOW cells with a running hit count
// reset clears wrap count, rise time, measure stage, window, hit count and output valid, and loads config defaults
`timescale 1ns / 1ps
`default_nettype none
module echo_width_presence_window_unit #(
  parameter int unsigned WINDOW     = ewpw_pkg::WindowDef,
  parameter int unsigned TICK_SHIFT = ewpw_pkg::TickShiftDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // timer_value [15:0]
  input  wire logic [ewpw_pkg::TimerW-1:0]   s_axis_tdata,
  // func [1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // echo_us [15:0], hit [16], hit_count [20:17], stop [21], zero [23:22]
  output logic [ewpw_pkg::OutW-1:0]          m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ewpw_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [ewpw_pkg::CfgW-1:0]     cfg_wdata_i
);
  import ewpw_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic [UsW-1:0]     min_us_q, min_us_d;
  logic [UsW-1:0]     max_us_q, max_us_d;
  logic [HitCntW-1:0] min_hits_q, min_hits_d;

  ewpw_meas_t meas;
  logic       accept;
  logic       out_rdy;
  logic       drain;

  logic [WINDOW-1:0] cells_q;
  logic              hit;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntMaxW-1:0] cnt_ext;
  logic [HitCntW-1:0] hit_cnt;

  logic               out_vld_q, out_vld_d;
  logic [OutW-1:0]    out_q, out_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_us_d   = min_us_q;
    max_us_d   = max_us_q;
    min_hits_d = min_hits_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgMinUs:   min_us_d   = cfg_wdata_i;
        CfgMaxUs:   max_us_d   = cfg_wdata_i;
        CfgMinHits: min_hits_d = cfg_wdata_i[HitCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_us_q   <= MinUsRst;
      max_us_q   <= MaxUsRst;
      min_hits_q <= MinHitsRst;
    end else begin
      min_us_q   <= min_us_d;
      max_us_q   <= max_us_d;
      min_hits_q <= min_hits_d;
    end
  end

  // handshake
  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign drain         = meas.vld && out_rdy;
  assign s_axis_tready = !meas.vld || out_rdy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ewpw_stamp #(
    .TICK_SHIFT(TICK_SHIFT)
  ) u_stamp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (s_axis_tuser),
    .timer_i  (s_axis_tdata),
    .drain_i  (drain),
    .meas_o   (meas)
  );

  assign hit = (meas.width > min_us_q) && (meas.width < max_us_q);

  // hit window chain, newest at cell 0
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic d;
    if (g == 0) begin : g_head
      assign d = hit;
    end else begin : g_link
      assign d = cells_q[g-1];
    end
    ewpw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (drain),
      .d_i     (d),
      .q_o     (cells_q[g])
    );
  end

  always_comb begin
    cnt_d = cnt_q + CntW'(hit) - CntW'(cells_q[WINDOW-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (drain) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_ext = CntMaxW'(cnt_d);
  assign hit_cnt = (cnt_ext > CntMaxW'(HitCntSat)) ? HitCntSat : cnt_ext[HitCntW-1:0];

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_rdy) begin
      out_vld_d = meas.vld;
    end
    if (drain) begin
      out_d = {2'b00, (hit_cnt < min_hits_q), hit_cnt, hit, meas.width};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // checks
  a_cnt_matches_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == 32'($countones(cells_q)))
    else $error("hit count differs from window contents");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (meas.vld && out_vld_q))
    else $error("input stalled with free stage");

  a_out_from_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(meas.vld))
    else $error("result without measured word");

endmodule
`default_nettype wire

### hw/rtl/ewpw_cell.sv
// one slot of the hit window chain
`timescale 1ns / 1ps
`default_nettype none
module ewpw_cell (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic shift_i,
  input  wire logic d_i,
  output logic      q_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = shift_i ? d_i : bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign q_o = bit_q;

endmodule
`default_nettype wire

### hw/rtl/ewpw_stamp.sv
// timestamp extension, rise capture and echo width stage
`timescale 1ns / 1ps
`default_nettype none
module ewpw_stamp #(
  parameter int unsigned TICK_SHIFT = ewpw_pkg::TickShiftDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [1:0]                     func_i,
  input  wire logic [ewpw_pkg::TimerW-1:0]    timer_i,
  input  wire logic                           drain_i,
  output ewpw_pkg::ewpw_meas_t                meas_o
);
  import ewpw_pkg::*;

  logic [TimerW-1:0] wrap_q, wrap_d;
  logic [StampW-1:0] rise_q, rise_d;
  ewpw_meas_t        meas_q, meas_d;

  logic [StampW-1:0] fall_stamp;
  logic [StampW-1:0] diff;
  logic [StampW-1:0] shifted;
  logic              is_fall;

  assign fall_stamp = {wrap_q, timer_i};
  assign diff       = fall_stamp - rise_q;
  assign shifted    = diff >> TICK_SHIFT;
  assign is_fall    = accept_i && (func_i == FuncFall);

  always_comb begin
    wrap_d = wrap_q;
    rise_d = rise_q;
    meas_d = meas_q;
    if (drain_i) begin
      meas_d.vld = 1'b0;
    end
    if (accept_i) begin
      case (func_i)
        FuncTick: begin
          wrap_d = wrap_q + TimerW'(1);
        end
        FuncRise: begin
          rise_d = fall_stamp;
        end
        FuncFall: begin
          wrap_d = '0;
        end
        default: begin
        end
      endcase
    end
    if (is_fall) begin
      meas_d.vld = 1'b1;
      if (fall_stamp > rise_q) begin
        meas_d.width = (|shifted[StampW-1:UsW]) ? '1 : shifted[UsW-1:0];
      end else begin
        meas_d.width = BadEchoUs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
      rise_q <= '0;
      meas_q <= '0;
    end else begin
      wrap_q <= wrap_d;
      rise_q <= rise_d;
      meas_q <= meas_d;
    end
  end

  assign meas_o = meas_q;

endmodule
`default_nettype wire
